FILE: hdl/npc_pkg.sv
// ----------------------------------------------------------------------------
// npc_pkg
// Shared widths, operation codes and the scan tag for the nearest palette
// color match block.
// ----------------------------------------------------------------------------
`default_nettype none

package npc_pkg;

  localparam int COLOR_W = 24;
  localparam int CHAN_W  = 8;
  localparam int IDX_W   = 8;
  localparam int DIST_W  = 18;
  localparam int SIZE_W  = 9;
  localparam int SQ_W    = 2 * CHAN_W;

  // Number of indices that an entry index and best_index can address.
  localparam int INDEX_REACH = 256;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;
  localparam logic [DIST_W-1:0] DIST_MAX   = 18'd195075;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_MATCH = 1'b1;

  // Travels alongside each palette entry as it moves down the scan pipeline.
  typedef struct packed {
    logic             valid;
    logic             last;
    logic [IDX_W-1:0] idx;
  } scan_tag_t;

endpackage

`default_nettype wire

FILE: hdl/nearest_palette_color_match_top.sv
// ----------------------------------------------------------------------------
// nearest_palette_color_match_top
// Nearest palette color search by squared RGB distance over a stored palette.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on in_valid/in_ready. A write word (in_op = 0) stores
//   in_color at in_entry_index and produces no result; indices at or above
//   PALETTE_DEPTH are dropped. A match word (in_op = 1) starts a
//   scan of entries 0 .. N-1, where N is cfg palette size clamped to at least
//   1 and at most min(PALETTE_DEPTH, 256).
//   The scan reads one entry per cycle from the palette memory and runs it
//   through one distance unit. Each entry passes the memory read register
//   and the distance register; the running best and the S_DONE state are
//   registered, then the result word goes out on out_valid/out_ready.
//   in_ready is low for the whole scan and high again as the result loads.
//   The result sits in an output register; a new word is accepted while it
//   waits. If the receiver still holds the previous result when a scan ends,
//   the block waits with in_ready low until that result is taken.
//   The palette size register is written through cfg_wr_en/cfg_wr_data and
//   should only change while no match is in flight.
//   Reset (rst_n low, synchronous) clears the control state and sets the
//   palette size to 256; palette contents stay undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_palette_color_match_top
  import npc_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic               in_op,
  input  wire logic [IDX_W-1:0]   in_entry_index,
  input  wire logic [COLOR_W-1:0] in_color,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic [IDX_W-1:0]   out_best_index,
  output      logic [DIST_W-1:0]  out_best_distance,
  input  wire logic               cfg_wr_en,
  input  wire logic [SIZE_W-1:0]  cfg_wr_data
);

  localparam int AW    = $clog2(PALETTE_DEPTH);
  localparam int N_LIM = (PALETTE_DEPTH < INDEX_REACH) ? PALETTE_DEPTH : INDEX_REACH;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t             state_r;
  logic [SIZE_W-1:0]  size_r;
  logic [COLOR_W-1:0] color_r;
  logic [IDX_W-1:0]   last_idx_r;
  logic [IDX_W-1:0]   scan_idx_r;
  logic               iss_r;
  scan_tag_t          s1_tag_r;
  logic [IDX_W-1:0]   best_idx_r;
  logic [DIST_W-1:0]  best_d_r;
  logic               out_valid_r;
  logic [IDX_W-1:0]   out_idx_r;
  logic [DIST_W-1:0]  out_dist_r;

  logic               accept;
  logic               wr_en;
  logic [SIZE_W-1:0]  size_eff;
  logic [COLOR_W-1:0] rd_data;
  logic [DIST_W-1:0]  entry_dist;
  scan_tag_t          s2_tag;
  logic               take;
  logic               out_free;
  logic               out_load;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign wr_en    = accept && (in_op == OP_WRITE) && (32'(in_entry_index) < PALETTE_DEPTH);
  assign out_free = !out_valid_r || out_ready;
  assign out_load = (state_r == S_DONE) && out_free;

  always_comb begin
    if (size_r == '0) begin
      size_eff = SIZE_W'(1);
    end else if (32'(size_r) > N_LIM) begin
      size_eff = SIZE_W'(N_LIM);
    end else begin
      size_eff = size_r;
    end
  end

  // The first entry always seeds the running best; later ones replace it
  // only when strictly closer, so the lowest index wins a tie.
  assign take = s2_tag.valid && ((s2_tag.idx == '0) || (entry_dist < best_d_r));

  npc_palram #(
    .DEPTH (PALETTE_DEPTH)
  ) u_palram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(in_entry_index)),
    .wr_data (in_color),
    .rd_en   (iss_r),
    .rd_addr (AW'(scan_idx_r)),
    .rd_data (rd_data)
  );

  npc_dist u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .entry   (rd_data),
    .target  (color_r),
    .tag_in  (s1_tag_r),
    .sq_dist (entry_dist),
    .tag_out (s2_tag)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      size_r         <= SIZE_RESET;
      iss_r          <= 1'b0;
      s1_tag_r.valid <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        size_r <= cfg_wr_data;
      end

      s1_tag_r.valid <= iss_r;
      s1_tag_r.last  <= (scan_idx_r == last_idx_r);
      s1_tag_r.idx   <= scan_idx_r;

      if (take) begin
        best_idx_r <= s2_tag.idx;
        best_d_r   <= entry_dist;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept && (in_op == OP_MATCH)) begin
            color_r    <= in_color;
            last_idx_r <= IDX_W'(size_eff - SIZE_W'(1));
            scan_idx_r <= '0;
            iss_r      <= 1'b1;
            state_r    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (iss_r) begin
            if (scan_idx_r == last_idx_r) begin
              iss_r <= 1'b0;
            end else begin
              scan_idx_r <= scan_idx_r + IDX_W'(1);
            end
          end
          if (s2_tag.valid && s2_tag.last) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_idx_r   <= best_idx_r;
            out_dist_r  <= best_d_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_best_index    = out_idx_r;
  assign out_best_distance = out_dist_r;

endmodule

`default_nettype wire

FILE: hdl/npc_palram.sv
// ----------------------------------------------------------------------------
// npc_palram
// Palette storage: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module npc_palram
  import npc_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [COLOR_W-1:0]       wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [COLOR_W-1:0]       rd_data
);

  logic [COLOR_W-1:0] mem [DEPTH];
  logic [COLOR_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: hdl/npc_dist.sv
// ----------------------------------------------------------------------------
// npc_dist
// Distance unit: squared Euclidean RGB distance of one palette entry to the
// target color, registered, with the entry's scan tag carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module npc_dist
  import npc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [COLOR_W-1:0] entry,
  input  wire logic [COLOR_W-1:0] target,
  input  wire scan_tag_t          tag_in,
  output      logic [DIST_W-1:0]  sq_dist,
  output      scan_tag_t          tag_out
);

  logic [CHAN_W-1:0] diff [3];
  logic [SQ_W-1:0]   sq   [3];
  logic [DIST_W-1:0] dist_nxt;
  logic [DIST_W-1:0] dist_r;
  scan_tag_t         tag_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (entry[c*CHAN_W +: CHAN_W] >= target[c*CHAN_W +: CHAN_W]) begin
        diff[c] = entry[c*CHAN_W +: CHAN_W] - target[c*CHAN_W +: CHAN_W];
      end else begin
        diff[c] = target[c*CHAN_W +: CHAN_W] - entry[c*CHAN_W +: CHAN_W];
      end
      sq[c] = SQ_W'(diff[c]) * SQ_W'(diff[c]);
    end
    dist_nxt = DIST_W'(sq[0]) + DIST_W'(sq[1]) + DIST_W'(sq[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r.valid <= 1'b0;
    end else begin
      tag_r.valid <= tag_in.valid;
    end
    tag_r.last <= tag_in.last;
    tag_r.idx  <= tag_in.idx;
    dist_r     <= dist_nxt;
  end

  assign sq_dist = dist_r;
  assign tag_out = tag_r;

endmodule

`default_nettype wire

FILE: hdl/npc_checker.sv
// ----------------------------------------------------------------------------
// npc_checker
// Port-level checks for the nearest palette color match block, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

module npc_checker
  import npc_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               in_op,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [IDX_W-1:0]   out_best_index,
  input wire logic [DIST_W-1:0]  out_best_distance
);

  // A stalled result word must hold its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_best_index)
                                 && $stable(out_best_distance))
    else $error("result word changed while stalled");

  // A match word starts a scan, so the block is busy on the next cycle.
  a_match_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op == OP_MATCH) |=> !in_ready)
    else $error("block ready right after accepting a match word");

  // A write word leaves the block ready.
  a_write_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op == OP_WRITE) |=> in_ready)
    else $error("block busy after a write word");

  // The distance of three 8-bit channels cannot exceed three times 255 squared.
  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_best_distance <= DIST_MAX))
    else $error("result distance out of range");

  // A new result cannot appear in the cycle after a match word is accepted.
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op == OP_MATCH) && !out_valid |=> !out_valid)
    else $error("result appeared without a scan");

endmodule

bind nearest_palette_color_match_top npc_checker u_npc_checker (.*);

`default_nettype wire
